FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every rising edge, skipped while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/tqls_pkg.sv
// ----------------------------------------------------------------------------
// tqls_pkg
// shared widths, reset values, register codes and helpers for the q step
// ----------------------------------------------------------------------------
package tqls_pkg;

  // field widths
  localparam int STATE_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int EDRAW_W  = 16;
  localparam int ADRAW_W  = 32;
  localparam int ACT_W    = 4;
  localparam int SCNT_W   = 9;
  localparam int ACNT_W   = 5;
  localparam int RATE_W   = 17;
  localparam int CFG_IDX_W = 3;

  // default table geometry
  localparam int MAX_STATES_DEF  = 256;
  localparam int MAX_ACTIONS_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 3'd4;

  // register reset values
  localparam logic [SCNT_W-1:0] STATE_COUNT_RST  = 9'd256;
  localparam logic [ACNT_W-1:0] ACTION_COUNT_RST = 5'd16;
  localparam logic [RATE_W-1:0] EXPLORE_RATE_RST = 17'd6554;
  localparam logic [RATE_W-1:0] LEARN_RATE_RST   = 17'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST     = 17'd58982;

  // 1.0 in q1.16
  localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;

  // dividend bits consumed per cycle in the modulo unit
  localparam int MOD_STEP = 2;

  // operands of the value update
  typedef struct packed {
    logic signed [VALUE_W-1:0] reward;
    logic signed [VALUE_W-1:0] q;
    logic signed [VALUE_W-1:0] maxnext;
    logic        [RATE_W-1:0]  discount;
    logic        [RATE_W-1:0]  learn_rate;
  } upd_opnd_t;

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    return (r > ONE_Q16) ? ONE_Q16 : r;
  endfunction

endpackage

FILE: rtl/tqls_ram.sv
// ----------------------------------------------------------------------------
// tqls_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tqls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tqls_mod.sv
// ----------------------------------------------------------------------------
// tqls_mod
// iterative remainder of a 32-bit word by a small divisor, restoring form
// ----------------------------------------------------------------------------
module tqls_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tqls_pkg::ADRAW_W-1:0] dividend_i,
  input  logic [tqls_pkg::ACNT_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [tqls_pkg::ACNT_W-1:0]  rem_o
);

  localparam int DW     = tqls_pkg::ADRAW_W;
  localparam int NW     = tqls_pkg::ACNT_W;
  localparam int STEP   = tqls_pkg::MOD_STEP;
  localparam int CYCLES = DW / STEP;
  localparam int CNT_W  = $clog2(CYCLES + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    dvd_q, dvd_c;
  logic [NW-1:0]    rem_q, rem_c;
  logic [NW-1:0]    div_q;
  logic [NW:0]      trial;

  // STEP restoring steps on narrow values
  always_comb begin
    rem_c = rem_q;
    dvd_c = dvd_q;
    trial = '0;
    for (int k = 0; k < STEP; k++) begin
      trial = {rem_c, dvd_c[DW-1]};
      dvd_c = {dvd_c[DW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_c = trial[NW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(CYCLES);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_c;
      rem_q <= rem_c;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/tqls_update.sv
// ----------------------------------------------------------------------------
// tqls_update
// six-stage value update: q + round(alpha * (r + round(gamma * max) - q))
// ----------------------------------------------------------------------------
module tqls_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  tqls_pkg::upd_opnd_t               opnd_i,
  output logic                              done_o,
  output logic signed [tqls_pkg::VALUE_W-1:0] value_o
);

  localparam int STAGES = 6;
  localparam int RW     = tqls_pkg::RATE_W;
  localparam int VW     = tqls_pkg::VALUE_W;
  localparam int P1_W   = RW + 1 + VW;
  localparam int G_W    = P1_W - 16;
  localparam int D_W    = VW + 4;
  localparam int P2_W   = RW + 1 + D_W;
  localparam int R_W    = P2_W - 16;
  localparam int NV_W   = R_W + 1;

  localparam logic signed [P1_W-1:0] HALF1   = P1_W'(32768);
  localparam logic signed [P2_W-1:0] HALF2   = P2_W'(32768);
  localparam logic signed [NV_W-1:0] SAT_MAX = NV_W'(64'sh7fffffff);
  localparam logic signed [NV_W-1:0] SAT_MIN = NV_W'(-64'sh80000000);

  logic [STAGES-1:0] vld_q;

  logic [RW-1:0] disc_c, alpha_c;
  logic signed [P1_W-1:0] p1_d, p1_q;
  logic signed [G_W-1:0]  g_d, g_q;
  logic signed [D_W-1:0]  d_d, d_q;
  logic signed [P2_W-1:0] p2_d, p2_q;
  logic signed [R_W-1:0]  r_d, r_q;
  logic signed [NV_W-1:0] nv;
  logic signed [VW-1:0]   value_d, value_q;

  assign disc_c  = tqls_pkg::clamp_rate(opnd_i.discount);
  assign alpha_c = tqls_pkg::clamp_rate(opnd_i.learn_rate);

  always_comb begin
    p1_d = $signed({1'b0, disc_c}) * $signed(opnd_i.maxnext);
    // round to nearest, ties up: floor(x / 2^16 + 0.5)
    g_d  = G_W'((p1_q + HALF1) >>> 16);
    d_d  = D_W'($signed(opnd_i.reward)) + D_W'(g_q) - D_W'($signed(opnd_i.q));
    p2_d = $signed({1'b0, alpha_c}) * d_q;
    r_d  = R_W'((p2_q + HALF2) >>> 16);
    nv   = NV_W'($signed(opnd_i.q)) + NV_W'(r_q);
    if (nv > SAT_MAX) begin
      value_d = VW'(SAT_MAX);
    end else if (nv < SAT_MIN) begin
      value_d = VW'(SAT_MIN);
    end else begin
      value_d = VW'(nv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p1_q <= p1_d;
    end
    if (vld_q[0]) begin
      g_q <= g_d;
    end
    if (vld_q[1]) begin
      d_q <= d_d;
    end
    if (vld_q[2]) begin
      p2_q <= p2_d;
    end
    if (vld_q[3]) begin
      r_q <= r_d;
    end
    if (vld_q[4]) begin
      value_q <= value_d;
    end
  end

  assign done_o  = vld_q[STAGES-1];
  assign value_o = value_q;

endmodule

FILE: rtl/tabular_q_learning_step.sv
// An index error goes straight to the result. Other steps scan the next-state row; a
// greedy step then scans the current row, an explored one awaits the remainder; then q
// is read and updated. Scans cover the na actions in use. One step is in flight at a
// time, and the next beat can be taken the cycle after the result loads. After reset
// the table is swept to zero, one entry a cycle, MAX_STATES*MAX_ACTIONS entries (4096
// by default), with in_stall_o high; config writes are taken throughout.
// ----------------------------------------------------------------------------
// tabular_q_learning_step
// epsilon-greedy action choice and q-table update on a one-write, one-read port table ram
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tabular_q_learning_step #(
  parameter int MAX_STATES  = tqls_pkg::MAX_STATES_DEF,
  parameter int MAX_ACTIONS = tqls_pkg::MAX_ACTIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tqls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tqls_pkg::RATE_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tqls_pkg::STATE_W-1:0]        current_state_i,
  input  logic [tqls_pkg::STATE_W-1:0]        following_state_i,
  input  logic signed [tqls_pkg::VALUE_W-1:0] step_reward_i,
  input  logic [tqls_pkg::EDRAW_W-1:0]        explore_draw_i,
  input  logic [tqls_pkg::ADRAW_W-1:0]        action_draw_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tqls_pkg::ACT_W-1:0]          chosen_action_o,
  output logic                                explored_o,
  output logic signed [tqls_pkg::VALUE_W-1:0] new_value_o,
  output logic                                index_error_o
);

  localparam int TDEPTH = MAX_STATES * MAX_ACTIONS;
  localparam int TW     = $clog2(TDEPTH);
  localparam int AIW    = $clog2(MAX_ACTIONS);
  localparam int VW     = tqls_pkg::VALUE_W;
  localparam int ACT_W  = tqls_pkg::ACT_W;
  localparam int ACNT_W = tqls_pkg::ACNT_W;
  localparam int SCNT_W = tqls_pkg::SCNT_W;
  localparam int RATE_W = tqls_pkg::RATE_W;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_CLEAR    = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd1;
  localparam logic [ST_W-1:0] ST_SCAN_NXT = 4'd2;
  localparam logic [ST_W-1:0] ST_SCAN_CUR = 4'd3;
  localparam logic [ST_W-1:0] ST_WAIT_ACT = 4'd4;
  localparam logic [ST_W-1:0] ST_READ_Q   = 4'd5;
  localparam logic [ST_W-1:0] ST_Q_WAIT   = 4'd6;
  localparam logic [ST_W-1:0] ST_CALC     = 4'd7;
  localparam logic [ST_W-1:0] ST_DONE     = 4'd8;

  // configuration registers
  logic [SCNT_W-1:0] state_count_q;
  logic [ACNT_W-1:0] action_count_q;
  logic [RATE_W-1:0] explore_rate_q, learn_rate_q, discount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q  <= tqls_pkg::STATE_COUNT_RST;
      action_count_q <= tqls_pkg::ACTION_COUNT_RST;
      explore_rate_q <= tqls_pkg::EXPLORE_RATE_RST;
      learn_rate_q   <= tqls_pkg::LEARN_RATE_RST;
      discount_q     <= tqls_pkg::DISCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tqls_pkg::CFG_STATE_COUNT:  state_count_q  <= cfg_data_i[SCNT_W-1:0];
        tqls_pkg::CFG_ACTION_COUNT: action_count_q <= cfg_data_i[ACNT_W-1:0];
        tqls_pkg::CFG_EXPLORE_RATE: explore_rate_q <= cfg_data_i;
        tqls_pkg::CFG_LEARN_RATE:   learn_rate_q   <= cfg_data_i;
        tqls_pkg::CFG_DISCOUNT:     discount_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // action count in use, clamped to 1..MAX_ACTIONS
  logic [AIW-1:0]    na_m1;
  logic [ACNT_W-1:0] na;

  always_comb begin
    if (action_count_q == '0) begin
      na_m1 = '0;
      na    = ACNT_W'(1);
    end else if (32'(action_count_q) > MAX_ACTIONS) begin
      na_m1 = AIW'(MAX_ACTIONS - 1);
      na    = ACNT_W'(MAX_ACTIONS);
    end else begin
      na_m1 = AIW'(action_count_q - ACNT_W'(1));
      na    = action_count_q;
    end
  end

  // input checks
  logic cur_ok, nxt_ok, in_err, in_explore;
  logic [TW-1:0] in_cur_base, in_nxt_base;

  assign cur_ok = (SCNT_W'(current_state_i) < state_count_q)
               && (32'(current_state_i) < MAX_STATES);
  assign nxt_ok = (SCNT_W'(following_state_i) < state_count_q)
               && (32'(following_state_i) < MAX_STATES);
  assign in_err      = !cur_ok || !nxt_ok;
  assign in_explore  = {1'b0, explore_draw_i} < explore_rate_q;
  assign in_cur_base = TW'(current_state_i) * TW'(MAX_ACTIONS);
  assign in_nxt_base = TW'(following_state_i) * TW'(MAX_ACTIONS);

  // sequencer state
  logic [ST_W-1:0]     state_q, state_d;
  logic [TW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [TW-1:0]       cur_base_q, cur_base_d, nxt_base_q, nxt_base_d;
  logic signed [VW-1:0] reward_q, reward_d;
  logic                expl_q, expl_d, err_q, err_d;
  logic [AIW-1:0]      a_q, a_d, ridx_q, ridx_d;
  logic                issue_q, issue_d, rvalid_q, rvalid_d, first_q, first_d;
  logic signed [VW-1:0] best_q, best_d, maxnext_q, maxnext_d, q_q, q_d;
  logic [AIW-1:0]      best_idx_q, best_idx_d, act_q, act_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [ACT_W-1:0]    chosen_action_q, chosen_action_d;
  logic                explored_q, explored_d, index_error_q, index_error_d;
  logic signed [VW-1:0] new_value_q, new_value_d;

  // table ram
  logic          ram_we;
  logic [TW-1:0] ram_waddr, ram_raddr, scan_base;
  logic [VW-1:0] ram_wdata, ram_rdata;
  logic signed [VW-1:0] rd_val;

  // side units
  logic                 mod_start, mod_busy;
  logic [ACNT_W-1:0]    mod_rem;
  logic                 upd_start, upd_done;
  logic signed [VW-1:0] upd_value;
  tqls_pkg::upd_opnd_t  upd_opnd;

  logic scan_last, scan_hit, out_free;

  assign rd_val    = ram_rdata;
  assign scan_base = (state_q == ST_SCAN_NXT) ? nxt_base_q : cur_base_q;
  assign scan_last = rvalid_q && (ridx_q == na_m1);
  // strict compare keeps the lowest-numbered maximum
  assign scan_hit  = rvalid_q && (first_q || (rd_val > best_q));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    cur_base_d = cur_base_q;
    nxt_base_d = nxt_base_q;
    reward_d   = reward_q;
    expl_d     = expl_q;
    err_d      = err_q;
    a_d        = a_q;
    issue_d    = issue_q;
    rvalid_d   = 1'b0;
    ridx_d     = a_q;
    first_d    = first_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    maxnext_d  = maxnext_q;
    q_d        = q_q;
    act_d      = act_q;
    ram_we     = 1'b0;
    ram_waddr  = clr_cnt_q;
    ram_wdata  = '0;
    ram_raddr  = cur_base_q + TW'(act_q);
    mod_start  = 1'b0;
    upd_start  = 1'b0;

    out_valid_d     = out_valid_q && out_stall_i;
    chosen_action_d = chosen_action_q;
    explored_d      = explored_q;
    new_value_d     = new_value_q;
    index_error_d   = index_error_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + TW'(1);
        if (clr_cnt_q == TW'(TDEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d      = in_err;
          cur_base_d = in_cur_base;
          nxt_base_d = in_nxt_base;
          reward_d   = step_reward_i;
          expl_d     = in_explore;
          a_d        = '0;
          issue_d    = 1'b1;
          first_d    = 1'b1;
          mod_start  = !in_err && in_explore;
          state_d    = in_err ? ST_DONE : ST_SCAN_NXT;
        end
      end
      ST_SCAN_NXT, ST_SCAN_CUR: begin
        ram_raddr = scan_base + TW'(a_q);
        if (issue_q) begin
          rvalid_d = 1'b1;
          ridx_d   = a_q;
          a_d      = a_q + AIW'(1);
          if (a_q == na_m1) begin
            issue_d = 1'b0;
          end
        end
        if (scan_hit) begin
          best_d     = rd_val;
          best_idx_d = ridx_q;
          first_d    = 1'b0;
        end
        if (scan_last) begin
          if (state_q == ST_SCAN_NXT) begin
            maxnext_d = scan_hit ? rd_val : best_q;
            a_d       = '0;
            issue_d   = 1'b1;
            first_d   = 1'b1;
            state_d   = expl_q ? ST_WAIT_ACT : ST_SCAN_CUR;
          end else begin
            act_d   = scan_hit ? ridx_q : best_idx_q;
            state_d = ST_READ_Q;
          end
        end
      end
      ST_WAIT_ACT: begin
        if (!mod_busy) begin
          act_d   = AIW'(mod_rem);
          state_d = ST_READ_Q;
        end
      end
      ST_READ_Q: begin
        state_d = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        q_d       = rd_val;
        upd_start = 1'b1;
        state_d   = ST_CALC;
      end
      ST_CALC: begin
        if (upd_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ram_we          = !err_q;
          ram_waddr       = cur_base_q + TW'(act_q);
          ram_wdata       = upd_value;
          out_valid_d     = 1'b1;
          chosen_action_d = err_q ? '0 : ACT_W'(act_q);
          explored_d      = !err_q && expl_q;
          new_value_d     = err_q ? '0 : upd_value;
          index_error_d   = err_q;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      issue_q     <= 1'b0;
      rvalid_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      issue_q     <= issue_d;
      rvalid_q    <= rvalid_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_base_q      <= cur_base_d;
    nxt_base_q      <= nxt_base_d;
    reward_q        <= reward_d;
    expl_q          <= expl_d;
    err_q           <= err_d;
    a_q             <= a_d;
    ridx_q          <= ridx_d;
    best_q          <= best_d;
    best_idx_q      <= best_idx_d;
    maxnext_q       <= maxnext_d;
    q_q             <= q_d;
    act_q           <= act_d;
    chosen_action_q <= chosen_action_d;
    explored_q      <= explored_d;
    new_value_q     <= new_value_d;
    index_error_q   <= index_error_d;
  end

  tqls_ram #(
    .WIDTH (VW),
    .DEPTH (TDEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tqls_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (action_draw_i),
    .divisor_i  (na),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  assign upd_opnd.reward     = reward_q;
  assign upd_opnd.q          = q_q;
  assign upd_opnd.maxnext    = maxnext_q;
  assign upd_opnd.discount   = discount_q;
  assign upd_opnd.learn_rate = learn_rate_q;

  tqls_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (upd_start),
    .opnd_i  (upd_opnd),
    .done_o  (upd_done),
    .value_o (upd_value)
  );

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = chosen_action_q;
  assign explored_o      = explored_q;
  assign new_value_o     = new_value_q;
  assign index_error_o   = index_error_q;

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(new_value_o)), "result beat changed while stalled")
  `ASSERT_RST(a_act_range, clk_i, rst_ni, (state_q == ST_READ_Q) |-> (act_q <= na_m1), "action beyond count")
  `ASSERT_RST(a_act_ready, clk_i, rst_ni, (state_q == ST_READ_Q) |-> !mod_busy, "action read before remainder")
  `ASSERT_RST(a_rd_in_scan, clk_i, rst_ni, rvalid_q |-> (state_q == ST_SCAN_NXT || state_q == ST_SCAN_CUR), "row data outside scan")
  `ASSERT_RST(a_upd_in_calc, clk_i, rst_ni, upd_done |-> (state_q == ST_CALC), "update finished while not waiting")

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the q-learning step: a shadow q table predicts every
// beat, results are compared in order under random idling on both channels
// ----------------------------------------------------------------------------
module tb;

  localparam int STATE_W         = tqls_pkg::STATE_W;
  localparam int VALUE_W         = tqls_pkg::VALUE_W;
  localparam int EDRAW_W         = tqls_pkg::EDRAW_W;
  localparam int ADRAW_W         = tqls_pkg::ADRAW_W;
  localparam int ACT_W           = tqls_pkg::ACT_W;
  localparam int SCNT_W          = tqls_pkg::SCNT_W;
  localparam int ACNT_W          = tqls_pkg::ACNT_W;
  localparam int RATE_W          = tqls_pkg::RATE_W;
  localparam int CFG_IDX_W       = tqls_pkg::CFG_IDX_W;
  localparam int MAX_STATES_DEF  = tqls_pkg::MAX_STATES_DEF;
  localparam int MAX_ACTIONS_DEF = tqls_pkg::MAX_ACTIONS_DEF;
  localparam logic [RATE_W-1:0] ONE_Q16 = tqls_pkg::ONE_Q16;

  typedef struct packed {
    logic [STATE_W-1:0]        cur_state;
    logic [STATE_W-1:0]        nxt_state;
    logic signed [VALUE_W-1:0] reward;
    logic [EDRAW_W-1:0]        e_draw;
    logic [ADRAW_W-1:0]        a_draw;
  } step_t;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic                      explored;
    logic signed [VALUE_W-1:0] value;
    logic                      index_error;
  } outcome_t;

  localparam int     TABLE_DEPTH  = MAX_STATES_DEF * MAX_ACTIONS_DEF;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     HOLD_CYCLES  = 500;
  localparam int     HOLD_AFTER   = 150;
  localparam int     RAND_PHASES  = 10;
  localparam int     PHASE_STEPS  = 115;
  localparam int     NOISE_PCT    = 12;
  localparam int     REWARD_SPAN  = 4 << 16;
  localparam longint VALUE_MAX    = 64'sd2147483647;
  localparam longint VALUE_MIN    = -64'sd2147483648;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [RATE_W-1:0]     cfg_data_i        = '0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_stall_o;
  logic [STATE_W-1:0]    current_state_i   = '0;
  logic [STATE_W-1:0]    following_state_i = '0;
  logic signed [VALUE_W-1:0] step_reward_i = '0;
  logic [EDRAW_W-1:0]    explore_draw_i    = '0;
  logic [ADRAW_W-1:0]    action_draw_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i       = 1'b0;
  logic [ACT_W-1:0]      chosen_action_o;
  logic                  explored_o;
  logic signed [VALUE_W-1:0] new_value_o;
  logic                  index_error_o;

  // shadow of the block's registers and table
  logic [SCNT_W-1:0]         shadow_states   = tqls_pkg::STATE_COUNT_RST;
  logic [ACNT_W-1:0]         shadow_actions  = tqls_pkg::ACTION_COUNT_RST;
  logic [RATE_W-1:0]         shadow_explore  = tqls_pkg::EXPLORE_RATE_RST;
  logic [RATE_W-1:0]         shadow_learn    = tqls_pkg::LEARN_RATE_RST;
  logic [RATE_W-1:0]         shadow_discount = tqls_pkg::DISCOUNT_RST;
  logic signed [VALUE_W-1:0] q_shadow [TABLE_DEPTH] = '{default: '0};

  step_t    step_queue[$];
  outcome_t expected_outcomes[$];

  logic beat_taken    = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   outcomes_seen = 0;
  int   failures      = 0;
  int   n_steps       = 0;
  int   n_explored    = 0;
  int   n_greedy      = 0;
  int   n_index_err   = 0;
  int   n_settings    = 0;
  bit   hold_used     = 1'b0;
  int   hold_left     = 0;

  tabular_q_learning_step u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .current_state_i   (current_state_i),
    .following_state_i (following_state_i),
    .step_reward_i     (step_reward_i),
    .explore_draw_i    (explore_draw_i),
    .action_draw_i     (action_draw_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .chosen_action_o   (chosen_action_o),
    .explored_o        (explored_o),
    .new_value_o       (new_value_o),
    .index_error_o     (index_error_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // one learning step on the shadow table, returns what the block should report
  function automatic outcome_t learn_step(step_t s);
    outcome_t    o;
    int unsigned ns;
    int unsigned na;
    int unsigned act;
    int unsigned row;
    int unsigned nrow;
    longint      gamma_q;
    longint      alpha_q;
    longint      best;
    longint      next_max;
    longint      cur_q;
    longint      target;
    longint      fresh;
    o = '0;
    ns = (shadow_states > MAX_STATES_DEF) ? MAX_STATES_DEF : shadow_states;
    na = (shadow_actions == 0) ? 1 :
         (shadow_actions > MAX_ACTIONS_DEF) ? MAX_ACTIONS_DEF : shadow_actions;
    gamma_q = (shadow_discount > ONE_Q16) ? ONE_Q16 : shadow_discount;
    alpha_q = (shadow_learn > ONE_Q16) ? ONE_Q16 : shadow_learn;
    if (s.cur_state >= ns || s.nxt_state >= ns) begin
      o.index_error = 1'b1;
      return o;
    end
    row  = s.cur_state * MAX_ACTIONS_DEF;
    nrow = s.nxt_state * MAX_ACTIONS_DEF;
    o.explored = (s.e_draw < shadow_explore);
    if (o.explored) begin
      act = s.a_draw % na;
    end else begin
      // strict compare keeps the lowest-numbered maximum
      act  = 0;
      best = q_shadow[row];
      for (int a = 1; a < na; a++) begin
        if (q_shadow[row + a] > best) begin
          best = q_shadow[row + a];
          act  = a;
        end
      end
    end
    // max over the next row is taken before the write-back
    next_max = q_shadow[nrow];
    for (int a = 1; a < na; a++) begin
      if (q_shadow[nrow + a] > next_max) next_max = q_shadow[nrow + a];
    end
    cur_q  = q_shadow[row + act];
    target = longint'($signed(s.reward)) + ((gamma_q * next_max + 32768) >>> 16);
    fresh  = cur_q + ((alpha_q * (target - cur_q) + 32768) >>> 16);
    if (fresh > VALUE_MAX) fresh = VALUE_MAX;
    if (fresh < VALUE_MIN) fresh = VALUE_MIN;
    q_shadow[row + act] = fresh[VALUE_W-1:0];
    o.action = act[ACT_W-1:0];
    o.value  = fresh[VALUE_W-1:0];
    return o;
  endfunction

  function automatic step_t random_step(int unsigned ns);
    step_t s;
    if (ns == 0 || $urandom_range(0, 99) < NOISE_PCT) begin
      s.cur_state = STATE_W'($urandom);
      s.nxt_state = STATE_W'($urandom);
    end else begin
      s.cur_state = STATE_W'($urandom_range(0, ns - 1));
      s.nxt_state = STATE_W'($urandom_range(0, ns - 1));
    end
    // mostly small rewards so values build up, some anywhere in range
    if ($urandom_range(0, 99) < 70)
      s.reward = int'($urandom_range(0, 2 * REWARD_SPAN)) - REWARD_SPAN;
    else
      s.reward = $urandom;
    s.e_draw = EDRAW_W'($urandom);
    s.a_draw = $urandom;
    return s;
  endfunction

  function automatic void push_step(int unsigned cur, int unsigned nxt, int unsigned rew,
                                    int unsigned ed, int unsigned ad);
    step_t s;
    s.cur_state = cur[STATE_W-1:0];
    s.nxt_state = nxt[STATE_W-1:0];
    s.reward    = rew;
    s.e_draw    = ed[EDRAW_W-1:0];
    s.a_draw    = ad;
    step_queue.push_back(s);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[RATE_W-1:0];
  endtask

  task automatic program_regs(int unsigned sc, int unsigned ac, int unsigned er,
                              int unsigned lr, int unsigned dc);
    write_reg(tqls_pkg::CFG_STATE_COUNT, sc);
    write_reg(tqls_pkg::CFG_ACTION_COUNT, ac);
    write_reg(tqls_pkg::CFG_EXPLORE_RATE, er);
    write_reg(tqls_pkg::CFG_LEARN_RATE, lr);
    write_reg(tqls_pkg::CFG_DISCOUNT, dc);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (step_queue.size() != 0 || in_valid_i || expected_outcomes.size() != 0);
  endtask

  // input side: present the next queued step once the current beat is gone
  always @(negedge clk_i) begin : driver
    step_t s;
    if (!in_valid_i || beat_taken) begin
      if (step_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s = step_queue.pop_front();
        current_state_i   <= s.cur_state;
        following_state_i <= s.nxt_state;
        step_reward_i     <= s.reward;
        explore_draw_i    <= s.e_draw;
        action_draw_i     <= s.a_draw;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stall, with one long hold-off to back the block up
  always @(negedge clk_i) begin : receiver
    if (!hold_used && outcomes_seen >= HOLD_AFTER) begin
      hold_used   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    outcome_t got;
    outcome_t want;
    step_t    s;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tqls_pkg::CFG_STATE_COUNT:  shadow_states   = cfg_data_i[SCNT_W-1:0];
        tqls_pkg::CFG_ACTION_COUNT: shadow_actions  = cfg_data_i[ACNT_W-1:0];
        tqls_pkg::CFG_EXPLORE_RATE: shadow_explore  = cfg_data_i;
        tqls_pkg::CFG_LEARN_RATE:   shadow_learn    = cfg_data_i;
        tqls_pkg::CFG_DISCOUNT:     shadow_discount = cfg_data_i;
        default: ;
      endcase
    end
    if (out_valid_o && !out_stall_i) begin
      got.action      = chosen_action_o;
      got.explored    = explored_o;
      got.value       = new_value_o;
      got.index_error = index_error_o;
      outcomes_seen++;
      if (expected_outcomes.size() == 0) begin
        $error("result beat with no step outstanding");
        failures++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.action !== want.action) begin
          $error("chosen_action: expected %0d, got %0d", want.action, got.action);
          failures++;
        end
        if (got.explored !== want.explored) begin
          $error("explored: expected %0d, got %0d", want.explored, got.explored);
          failures++;
        end
        if (got.value !== want.value) begin
          $error("new_value: expected %0d, got %0d", want.value, got.value);
          failures++;
        end
        if (got.index_error !== want.index_error) begin
          $error("index_error: expected %0d, got %0d", want.index_error, got.index_error);
          failures++;
        end
      end
    end
    if (in_valid_i && !in_stall_o) begin
      s.cur_state = current_state_i;
      s.nxt_state = following_state_i;
      s.reward    = step_reward_i;
      s.e_draw    = explore_draw_i;
      s.a_draw    = action_draw_i;
      want = learn_step(s);
      expected_outcomes.push_back(want);
      n_steps++;
      if (want.index_error) n_index_err++;
      else if (want.explored) n_explored++;
      else n_greedy++;
    end
    beat_taken <= in_valid_i && !in_stall_o;
  end

  initial begin : sequencer
    int unsigned ns;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: ties on a zero row, explore edges, reward extremes
    push_step(0, 0, 32'h0001_0000, 16'hffff, 0);
    push_step(0, 1, 32'h7fff_ffff, 16'hffff, 0);
    push_step(0, 0, 32'h8000_0000, 0, 32'hffff_ffff);
    push_step(255, 255, 32'hffff_0000, 6553, 7);
    push_step(255, 0, 32'h0001_0000, 6554, 0);
    push_step(128, 127, 32'h5555_5555, 16'haaaa, 32'h5555_5555);
    push_step(127, 128, 32'haaaa_aaaa, 16'h5555, 32'haaaa_aaaa);
    wait_drained();

    // unused register indexes must be ignored
    for (int i = tqls_pkg::CFG_DISCOUNT + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), 32'hffff_ffff);
    // action count zero, rates above one
    program_regs(3, 0, 131071, 131071, 131071);
    push_step(2, 2, 32'h0000_8000, 16'hffff, 123);
    push_step(3, 0, 32'h0001_0000, 0, 0);
    push_step(0, 3, 32'h0001_0000, 0, 0);
    push_step(255, 255, 32'h0001_0000, 0, 0);
    push_step(1, 2, 32'h7fff_ffff, 100, 5);
    wait_drained();

    // state and action counts above the table, rates at zero
    program_regs(511, 31, 0, 0, 0);
    push_step(255, 254, 32'h0003_0000, 0, 9);
    push_step(0, 0, 32'h7fff_ffff, 0, 0);
    wait_drained();

    // no state in range
    program_regs(0, 16, 65536, 65536, 65536);
    push_step(0, 0, 32'h0001_0000, 0, 0);
    wait_drained();

    // rates at one, drive the value into both saturation limits
    program_regs(1, 2, 65536, 65536, 65536);
    push_step(0, 0, 32'h7fff_ffff, 16'hffff, 32'hffff_ffff);
    push_step(0, 0, 32'h7fff_ffff, 16'hffff, 32'hffff_ffff);
    push_step(0, 0, 32'h8000_0000, 16'hffff, 32'hffff_ffff);
    push_step(0, 0, 32'h8000_0000, 16'hffff, 32'hffff_ffff);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: program_regs(tqls_pkg::STATE_COUNT_RST, tqls_pkg::ACTION_COUNT_RST,
                        tqls_pkg::EXPLORE_RATE_RST, tqls_pkg::LEARN_RATE_RST,
                        tqls_pkg::DISCOUNT_RST);
        1: program_regs(4, 16, 16384, 32768, 58982);
        2: program_regs(8, 5, 0, 65536, 65536);
        3: program_regs(2, 1, 65536, 1, 0);
        4: program_regs(1, 31, 30000, 100000, 0);
        5: program_regs(511, 8, 32768, 6554, 65536);
        default: program_regs($urandom_range(1, 24), $urandom_range(0, 31),
                              $urandom_range(0, 70000), $urandom_range(0, 70000),
                              $urandom_range(0, 70000));
      endcase
      send_idle_pct = (p < 4) ? 26 : (p < 7) ? 71 : 0;
      recv_idle_pct = (p < 4) ? 71 : (p < 7) ? 26 : 0;
      ns = (shadow_states > MAX_STATES_DEF) ? MAX_STATES_DEF : shadow_states;
      for (int k = 0; k < PHASE_STEPS; k++) step_queue.push_back(random_step(ns));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d steps checked: %0d explored, %0d greedy, %0d with a bad state index",
             n_steps, n_explored, n_greedy, n_index_err);
    $display("%0d register settings applied, clamped and out-of-range values included",
             n_settings);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #6400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
